[src/rcfs_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfs_pkg
// Shared widths, register indexes, reset values and types of the RGB color
// fade sequencer.
// ----------------------------------------------------------------------------
package rcfs_pkg;

  // Width of the step counter and of the per-segment step limit.
  localparam int STEP_COUNT_BITS = 12;

  localparam int CHAN_W    = 8;
  localparam int COLOR_W   = 3 * CHAN_W;
  localparam int STEPS_W   = 12;
  localparam int SEG_W     = 2;
  localparam int CFG_IDX_W = 3;

  // Wider of the register and the counter, for the saturation compare.
  localparam int LIM_W = (STEP_COUNT_BITS > STEPS_W) ? STEP_COUNT_BITS : STEPS_W;
  localparam logic [LIM_W-1:0] STEP_CAP = LIM_W'((1 << STEP_COUNT_BITS) - 1);

  // Multiply/divide datapath widths.
  localparam int PROD_W = CHAN_W + STEP_COUNT_BITS;
  localparam int NUM_W  = PROD_W + 1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_ZERO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_TWO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COLOR_THREE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STEPS       = 3'd4;

  // Reset values.
  localparam logic [COLOR_W-1:0] COLOR_ZERO_RST  = 24'h0000FF;
  localparam logic [COLOR_W-1:0] COLOR_ONE_RST   = 24'h00FF00;
  localparam logic [COLOR_W-1:0] COLOR_TWO_RST   = 24'hFF0000;
  localparam logic [COLOR_W-1:0] COLOR_THREE_RST = 24'h0000FF;
  localparam logic [STEPS_W-1:0] STEPS_RST       = 12'd500;

  // Configuration seen by the sequencer.
  typedef struct packed {
    logic [3:0][COLOR_W-1:0]      color;
    logic [STEP_COUNT_BITS-1:0]   n_limit;
  } cfg_t;

  // Request to the shared multiply/divide unit.
  typedef struct packed {
    logic              start;
    logic              round_up;
    logic [CHAN_W-1:0] mag;
  } muldiv_req_t;

  // Response from the shared multiply/divide unit.
  typedef struct packed {
    logic              done;
    logic [CHAN_W-1:0] quot;
  } muldiv_rsp_t;

endpackage

[src/rcfs_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfs_if
// Valid/ready channels of the fade sequencer: tick beats in, color beats out.
// ----------------------------------------------------------------------------
interface rcfs_tick_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface rcfs_color_if;
  logic                       valid;
  logic                       ready;
  logic [rcfs_pkg::CHAN_W-1:0] red;
  logic [rcfs_pkg::CHAN_W-1:0] green;
  logic [rcfs_pkg::CHAN_W-1:0] blue;
  logic [rcfs_pkg::SEG_W-1:0]  segment_index;
  logic                       segment_end;
  logic                       cycle_end;

  modport source (output valid, output red, output green, output blue,
                  output segment_index, output segment_end, output cycle_end,
                  input ready);
  modport sink   (input valid, input red, input green, input blue,
                  input segment_index, input segment_end, input cycle_end,
                  output ready);
endinterface

[src/rcfs_cfg_regs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfs_cfg_regs
// Color and step registers with the write port, plus the clamped step limit.
// ----------------------------------------------------------------------------
module rcfs_cfg_regs (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rcfs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rcfs_pkg::COLOR_W-1:0]      cfg_data,
  output rcfs_pkg::cfg_t                    cfg
);

  logic [3:0][rcfs_pkg::COLOR_W-1:0] color;
  logic [rcfs_pkg::STEPS_W-1:0]      steps;
  logic [rcfs_pkg::LIM_W-1:0]        steps_ext;

  always_ff @(posedge clk) begin
    if (rst) begin
      color[0] <= rcfs_pkg::COLOR_ZERO_RST;
      color[1] <= rcfs_pkg::COLOR_ONE_RST;
      color[2] <= rcfs_pkg::COLOR_TWO_RST;
      color[3] <= rcfs_pkg::COLOR_THREE_RST;
      steps    <= rcfs_pkg::STEPS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        rcfs_pkg::CFG_COLOR_ZERO:  color[0] <= cfg_data;
        rcfs_pkg::CFG_COLOR_ONE:   color[1] <= cfg_data;
        rcfs_pkg::CFG_COLOR_TWO:   color[2] <= cfg_data;
        rcfs_pkg::CFG_COLOR_THREE: color[3] <= cfg_data;
        rcfs_pkg::CFG_STEPS:       steps    <= cfg_data[rcfs_pkg::STEPS_W-1:0];
        default: ;
      endcase
    end
  end

  assign steps_ext = rcfs_pkg::LIM_W'(steps);

  // zero steps acts as one; oversize counts saturate to the counter range
  always_comb begin
    cfg.color = color;
    if (steps == '0) begin
      cfg.n_limit = rcfs_pkg::STEP_COUNT_BITS'(1);
    end else if (steps_ext > rcfs_pkg::STEP_CAP) begin
      cfg.n_limit = rcfs_pkg::STEP_CAP[rcfs_pkg::STEP_COUNT_BITS-1:0];
    end else begin
      cfg.n_limit = steps_ext[rcfs_pkg::STEP_COUNT_BITS-1:0];
    end
  end

endmodule

[src/rcfs_muldiv.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rcfs_muldiv
// Shared unit: quot = floor(mag*k/n) or ceil(mag*k/n), a multiply step
// then one restoring-divide bit per cycle. Quotient never exceeds mag.
// ----------------------------------------------------------------------------
module rcfs_muldiv (
  input  logic                                clk,
  input  logic                                rst,
  input  rcfs_pkg::muldiv_req_t               req,
  input  logic [rcfs_pkg::STEP_COUNT_BITS-1:0] k,
  input  logic [rcfs_pkg::STEP_COUNT_BITS-1:0] n,
  output rcfs_pkg::muldiv_rsp_t               rsp
);

  typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_DIV} state_t;

  state_t                        state;
  logic [2:0]                    bit_cnt;
  logic [rcfs_pkg::NUM_W-1:0]    rem;
  logic [rcfs_pkg::NUM_W-1:0]    dsh;
  logic [rcfs_pkg::CHAN_W-1:0]   quot;
  logic [rcfs_pkg::CHAN_W-1:0]   mag_q;
  logic                          round_q;
  logic                          done;
  logic [rcfs_pkg::PROD_W-1:0]   prod;
  logic [rcfs_pkg::NUM_W-1:0]    bias;

  assign prod = rcfs_pkg::PROD_W'(mag_q) * rcfs_pkg::PROD_W'(k);
  // n - 1 added ahead of the floor divide gives the ceiling
  assign bias = round_q ? (rcfs_pkg::NUM_W'(n) - rcfs_pkg::NUM_W'(1)) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (req.start) begin
            mag_q   <= req.mag;
            round_q <= req.round_up;
            state   <= ST_MUL;
          end
        end
        ST_MUL: begin
          rem     <= rcfs_pkg::NUM_W'(prod) + bias;
          dsh     <= rcfs_pkg::NUM_W'(n) << (rcfs_pkg::CHAN_W - 1);
          quot    <= '0;
          bit_cnt <= 3'(rcfs_pkg::CHAN_W - 1);
          state   <= ST_DIV;
        end
        ST_DIV: begin
          if (rem >= dsh) begin
            rem  <= rem - dsh;
            quot <= {quot[rcfs_pkg::CHAN_W-2:0], 1'b1};
          end else begin
            quot <= {quot[rcfs_pkg::CHAN_W-2:0], 1'b0};
          end
          dsh <= dsh >> 1;
          if (bit_cnt == '0) begin
            done  <= 1'b1;
            state <= ST_IDLE;
          end else begin
            bit_cnt <= bit_cnt - 3'd1;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

  a_done_after_div: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == ST_DIV)
    else $error("muldiv done without a divide pass");

  a_quot_bound: assert property (@(posedge clk) disable iff (rst)
    done |-> quot <= mag_q)
    else $error("muldiv quotient exceeds channel span");

endmodule

[src/rgb_color_fade_sequencer_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_color_fade_sequencer_core
// Three-segment linear color fade; one color beat per tick beat.
// A new tick beat is taken only in idle, once the previous color beat is in the
// output register; the three channels go in turn through the shared multiply/
// divide unit (issue, multiply, 8 divide steps, writeback). A stalled color
// beat holds the next result in place.
// Reset: synchronous rst returns colors and steps to defaults, segment 0.
// ----------------------------------------------------------------------------
module rgb_color_fade_sequencer_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [rcfs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [rcfs_pkg::COLOR_W-1:0]   cfg_data,
  rcfs_tick_if.sink                      tick,
  rcfs_color_if.source                   color
);

  localparam int SCB = rcfs_pkg::STEP_COUNT_BITS;
  localparam int CW  = rcfs_pkg::CHAN_W;
  localparam logic [rcfs_pkg::SEG_W-1:0] SEG_LAST = 2'd2;

  typedef enum logic [1:0] {ST_IDLE, ST_ISSUE, ST_WAIT, ST_PUSH} state_t;
  typedef enum logic [1:0] {CH_RED, CH_GREEN, CH_BLUE} chan_t;

  rcfs_pkg::cfg_t        cfg;
  rcfs_pkg::muldiv_req_t req;
  rcfs_pkg::muldiv_rsp_t rsp;

  state_t                        state;
  chan_t                         ch;
  logic [rcfs_pkg::SEG_W-1:0]    current_segment;
  logic [SCB-1:0]                step_count;

  // per-item work registers
  logic [rcfs_pkg::COLOR_W-1:0]  a_q;
  logic [rcfs_pkg::COLOR_W-1:0]  b_q;
  logic [SCB-1:0]                k_q;
  logic [SCB-1:0]                n_q;
  logic [rcfs_pkg::SEG_W-1:0]    seg_q;
  logic                          seg_end_q;
  logic                          cyc_end_q;
  logic [CW-1:0]                 red_w;
  logic [CW-1:0]                 green_w;
  logic [CW-1:0]                 blue_w;

  // output register
  logic                          out_valid;
  logic [CW-1:0]                 out_red;
  logic [CW-1:0]                 out_green;
  logic [CW-1:0]                 out_blue;
  logic [rcfs_pkg::SEG_W-1:0]    out_seg;
  logic                          out_seg_end;
  logic                          out_cyc_end;

  // tick decode
  logic                          accept;
  logic [rcfs_pkg::SEG_W-1:0]    seg_cur;
  logic [SCB-1:0]                step_cur;
  logic [SCB:0]                  k_inc;
  logic                          seg_end;
  logic [SCB-1:0]                k_sel;

  // channel operands
  logic [CW-1:0]                 s_byte;
  logic [CW-1:0]                 e_byte;
  logic                          desc;
  logic [CW-1:0]                 ch_result;

  rcfs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  rcfs_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (req),
    .k   (k_q),
    .n   (n_q),
    .rsp (rsp)
  );

  assign tick.ready = (state == ST_IDLE);
  assign accept     = tick.valid && tick.ready;

  always_comb begin
    seg_cur  = tick.restart ? '0 : current_segment;
    if (seg_cur == 2'd3) begin
      seg_cur = '0;
    end
    step_cur = tick.restart ? '0 : step_count;
    k_inc    = {1'b0, step_cur} + (SCB+1)'(1);
    seg_end  = (k_inc >= {1'b0, cfg.n_limit});
    k_sel    = seg_end ? cfg.n_limit : k_inc[SCB-1:0];
  end

  always_comb begin
    case (ch)
      CH_RED: begin
        s_byte = a_q[3*CW-1:2*CW];
        e_byte = b_q[3*CW-1:2*CW];
      end
      CH_GREEN: begin
        s_byte = a_q[2*CW-1:CW];
        e_byte = b_q[2*CW-1:CW];
      end
      default: begin
        s_byte = a_q[CW-1:0];
        e_byte = b_q[CW-1:0];
      end
    endcase
    // falling channels round the step toward the end color
    desc         = (e_byte < s_byte);
    req.start    = (state == ST_ISSUE);
    req.round_up = desc;
    req.mag      = desc ? (s_byte - e_byte) : (e_byte - s_byte);
    ch_result    = desc ? (s_byte - rsp.quot) : (s_byte + rsp.quot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      ch              <= CH_RED;
      current_segment <= '0;
      step_count      <= '0;
      out_valid       <= 1'b0;
    end else begin
      // a push in the same cycle reloads the output register instead
      if (color.valid && color.ready && (state != ST_PUSH)) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            a_q       <= cfg.color[seg_cur];
            b_q       <= cfg.color[seg_cur + 2'd1];
            k_q       <= k_sel;
            n_q       <= cfg.n_limit;
            seg_q     <= seg_cur;
            seg_end_q <= seg_end;
            cyc_end_q <= seg_end && (seg_cur == SEG_LAST);
            if (seg_end) begin
              step_count      <= '0;
              current_segment <= (seg_cur == SEG_LAST) ? '0 : seg_cur + 2'd1;
            end else begin
              step_count      <= k_sel;
              current_segment <= seg_cur;
            end
            ch    <= CH_RED;
            state <= ST_ISSUE;
          end
        end
        ST_ISSUE: state <= ST_WAIT;
        ST_WAIT: begin
          if (rsp.done) begin
            case (ch)
              CH_RED: begin
                red_w <= ch_result;
                ch    <= CH_GREEN;
                state <= ST_ISSUE;
              end
              CH_GREEN: begin
                green_w <= ch_result;
                ch      <= CH_BLUE;
                state   <= ST_ISSUE;
              end
              default: begin
                blue_w <= ch_result;
                state  <= ST_PUSH;
              end
            endcase
          end
        end
        ST_PUSH: begin
          if (!out_valid || color.ready) begin
            out_valid   <= 1'b1;
            out_red     <= red_w;
            out_green   <= green_w;
            out_blue    <= blue_w;
            out_seg     <= seg_q;
            out_seg_end <= seg_end_q;
            out_cyc_end <= cyc_end_q;
            state       <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign color.valid         = out_valid;
  assign color.red           = out_red;
  assign color.green         = out_green;
  assign color.blue          = out_blue;
  assign color.segment_index = out_seg;
  assign color.segment_end   = out_seg_end;
  assign color.cycle_end     = out_cyc_end;

  a_busy_after_tick: assert property (@(posedge clk) disable iff (rst)
    accept |=> !tick.ready)
    else $error("tick taken while a fade step is in progress");

  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    color.valid |-> color.segment_index != 2'd3)
    else $error("unused segment index on color beat");

  a_cycle_needs_seg_end: assert property (@(posedge clk) disable iff (rst)
    (color.valid && !color.segment_end) |-> !color.cycle_end)
    else $error("cycle end without segment end");

endmodule
